>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the sRGB to CIELAB converter.
// No dependencies; the macros compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> src/rgblab_pkg.sv
// Types, constants and elaboration-time tables for the sRGB to CIELAB converter.
// No dependencies.
package rgblab_pkg;

  localparam int QB    = 30;        // internal fixed point: unsigned Q30
  localparam int LIN_W = QB + 1;    // linear light, <= 1.0
  localparam int T_W   = QB + 2;    // X/Xw, Y/Yw, Z/Zw row sums
  localparam int F_W   = QB + 1;    // f(t) and cube root search width

  localparam int LAT_LIN   = 1;
  localparam int LAT_MAT   = 2;
  localparam int LAT_CBRT  = 2 * F_W + 3;
  localparam int LAT_OUT   = 2;
  localparam int LAT_TOTAL = LAT_LIN + LAT_MAT + LAT_CBRT + LAT_OUT;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic        [14:0] lightness;
    logic signed [15:0] a_star;
    logic signed [15:0] b_star;
  } lab_t;

  typedef logic [2:0][LIN_W-1:0] lin_vec_t;
  typedef logic [2:0][T_W-1:0]   t_vec_t;
  typedef logic [2:0][F_W-1:0]   f_vec_t;

  typedef logic [LIN_W-1:0] lin_tab_t [256];
  typedef logic [QB-1:0]    coef_tab_t [9];

  // f(t) branch threshold: t * 24389 >= 216 * 2^30
  localparam logic [T_W-1:0] CBRT_TH =
    T_W'(((64'd216 << QB) + 64'd24388) / 64'd24389);
  // floor(m / 27) = (m * DIV27_M) >> DIV27_K for m < 2^31
  localparam int             DIV27_K = 36;
  localparam logic [31:0]    DIV27_M = 32'(((64'd1 << DIV27_K) + 64'd26) / 64'd27);
  localparam logic [F_W-1:0] FLIN_OFS = F_W'(((64'd4 << QB) + 64'd14) / 64'd29);

  localparam longint unsigned MAT_NUM [9] = '{
    64'd412395588967414216, 64'd357583430763714817, 64'd180492647381701573,
    64'd212586230785595551, 64'd715170303703410849, 64'd72200498643336226,
    64'd19297215491746944,  64'd119183864580848531, 64'd950497125131579766
  };
  localparam longint unsigned ROW_DEN [3] = '{
    64'd950456000000000000, 64'd1000000000000000000, 64'd1088754000000000000
  };

  function automatic longint unsigned qmul64(input longint unsigned a,
                                             input longint unsigned b);
    return (a * b + (64'd1 << (QB - 1))) >> QB;
  endfunction

  function automatic longint unsigned root5(input longint unsigned s);
    longint unsigned r;
    longint unsigned c;
    longint unsigned c2;
    r = 64'd0;
    for (int k = QB; k >= 0; k--) begin
      c = r | (64'd1 << k);
      if (c <= (64'd1 << QB)) begin
        c2 = qmul64(c, c);
        if (qmul64(qmul64(c2, c2), c) <= s) r = c;
      end
    end
    return r;
  endfunction

  function automatic longint unsigned linearize(input int code);
    longint unsigned cu;
    longint unsigned x;
    longint unsigned s;
    cu = longint'(code);
    if (cu <= 64'd10) return (cu * 64'd100 * (64'd1 << QB) + 64'd164730) / 64'd329460;
    x = (((64'd1000 * cu + 64'd14025) << QB) + 64'd134512) / 64'd269025;
    s = qmul64(x, x);
    return qmul64(s, root5(s));
  endfunction

  function automatic lin_tab_t build_lin_tab();
    lin_tab_t tab;
    for (int i = 0; i < 256; i++) tab[i] = LIN_W'(linearize(i));
    return tab;
  endfunction

  // round(num * 2^30 / den), long division
  function automatic longint unsigned qfrac(input longint unsigned num,
                                            input longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = 64'd0;
    rem = num;
    for (int i = 0; i < QB + 1; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q   = q | 64'd1;
      end
    end
    return (q + 64'd1) >> 1;
  endfunction

  function automatic coef_tab_t build_coef();
    coef_tab_t tab;
    for (int i = 0; i < 9; i++) tab[i] = QB'(qfrac(MAT_NUM[i], ROW_DEN[i / 3]));
    return tab;
  endfunction

  function automatic int lab_lmax(input int ofb);
    return ((100 << ofb) > 32767) ? 32767 : (100 << ofb);
  endfunction

  localparam lin_tab_t  LIN_TAB = build_lin_tab();
  localparam coef_tab_t COEF    = build_coef();

endpackage

>>> src/rgblab_lin.sv
// Inverse sRGB gamma: constant table lookup, one register stage.
// Depends on rgblab_pkg.
module rgblab_lin (
  input  logic                clk,
  input  logic                en,
  input  rgblab_pkg::pix_t    px,
  output rgblab_pkg::lin_vec_t lin
);

  rgblab_pkg::lin_vec_t lin_r;

  always_ff @(posedge clk) begin
    if (en) begin
      lin_r[0] <= rgblab_pkg::LIN_TAB[px.red];
      lin_r[1] <= rgblab_pkg::LIN_TAB[px.green];
      lin_r[2] <= rgblab_pkg::LIN_TAB[px.blue];
    end
  end

  assign lin = lin_r;

endmodule

>>> src/rgblab_mat.sv
// RGB-to-XYZ matrix with white point folded in; products, then row sums.
// Depends on rgblab_pkg.
module rgblab_mat (
  input  logic                 clk,
  input  logic                 en,
  input  rgblab_pkg::lin_vec_t lin,
  output rgblab_pkg::t_vec_t   t
);

  localparam int QB    = rgblab_pkg::QB;
  localparam int LIN_W = rgblab_pkg::LIN_W;
  localparam int T_W   = rgblab_pkg::T_W;
  localparam int PW    = QB + LIN_W + 1;

  function automatic logic [LIN_W-1:0] mul_q(input logic [QB-1:0] a,
                                             input logic [LIN_W-1:0] b);
    logic [PW-1:0] p;
    p = PW'(a) * PW'(b) + (PW'(1) << (QB - 1));
    return p[QB+LIN_W-1:QB];
  endfunction

  logic [8:0][LIN_W-1:0] prod_r;
  rgblab_pkg::t_vec_t    t_r;

  for (genvar row = 0; row < 3; row++) begin : g_row
    for (genvar col = 0; col < 3; col++) begin : g_col
      always_ff @(posedge clk) begin
        if (en) begin
          prod_r[row*3+col] <= mul_q(rgblab_pkg::COEF[row*3+col], lin[col]);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        t_r[row] <= T_W'(prod_r[row*3]) + T_W'(prod_r[row*3+1]) + T_W'(prod_r[row*3+2]);
      end
    end
  end

  assign t = t_r;

endmodule

>>> src/rgblab_cbrt.sv
// CIELAB f(t): bit-serial cube root pipeline (two stages per result bit)
// with the linear segment carried alongside. Depends on rgblab_pkg.
module rgblab_cbrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [rgblab_pkg::T_W-1:0]    t,
  output logic [rgblab_pkg::F_W-1:0]    f
);

  localparam int QB  = rgblab_pkg::QB;
  localparam int T_W = rgblab_pkg::T_W;
  localparam int F_W = rgblab_pkg::F_W;
  localparam int NB  = F_W;
  localparam int NW  = T_W + 11;
  localparam int DW  = 31 + 32;

  // linear segment prep
  logic [T_W-1:0] t1_r;
  logic [30:0]    n4_r;
  logic           flag1_r;
  logic [NW-1:0]  lin_n;
  logic [DW-1:0]  dprod;

  assign lin_n = NW'(t) * NW'(841) + NW'(54);
  assign dprod = DW'(n4_r) * DW'(rgblab_pkg::DIV27_M);

  always_ff @(posedge clk) begin
    if (en) begin
      t1_r    <= t;
      n4_r    <= lin_n[32:2];
      flag1_r <= (t >= rgblab_pkg::CBRT_TH);
    end
  end

  logic [T_W-1:0] t_s    [0:2*NB];
  logic [F_W-1:0] r_s    [0:2*NB];
  logic           flag_s [0:2*NB];
  logic [F_W-1:0] flin_s [0:2*NB];
  logic [F_W+1:0] c2_s   [0:NB-1];
  logic [F_W-1:0] f_r;

  always_ff @(posedge clk) begin
    if (en) begin
      t_s[0]    <= t1_r;
      r_s[0]    <= '0;
      flag_s[0] <= flag1_r;
      flin_s[0] <= F_W'(dprod[DW-1:rgblab_pkg::DIV27_K]) + rgblab_pkg::FLIN_OFS;
    end
  end

  for (genvar i = 0; i < NB; i++) begin : g_bit
    localparam int K = NB - 1 - i;
    logic [F_W-1:0]   ca;
    logic [2*F_W:0]   sq_rnd;
    logic [F_W-1:0]   cb;
    logic [2*F_W+2:0] cube_rnd;

    // stage A: square of the candidate
    always_comb begin
      ca     = r_s[2*i] | (F_W'(1) << K);
      sq_rnd = (2*F_W+1)'(ca) * (2*F_W+1)'(ca) + ((2*F_W+1)'(1) << (QB - 1));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        c2_s[i]       <= sq_rnd[2*F_W:QB];
        t_s[2*i+1]    <= t_s[2*i];
        r_s[2*i+1]    <= r_s[2*i];
        flag_s[2*i+1] <= flag_s[2*i];
        flin_s[2*i+1] <= flin_s[2*i];
      end
    end

    // stage B: cube and keep the bit if it does not pass t
    always_comb begin
      cb       = r_s[2*i+1] | (F_W'(1) << K);
      cube_rnd = (2*F_W+3)'(c2_s[i]) * (2*F_W+3)'(cb) + ((2*F_W+3)'(1) << (QB - 1));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_s[2*i+2]    <= (cube_rnd[2*F_W+2:QB] <= (2*F_W+3-QB)'(t_s[2*i+1])) ?
                         cb : r_s[2*i+1];
        t_s[2*i+2]    <= t_s[2*i+1];
        flag_s[2*i+2] <= flag_s[2*i+1];
        flin_s[2*i+2] <= flin_s[2*i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_r <= flag_s[2*NB] ? r_s[2*NB] : flin_s[2*NB];
    end
  end

  assign f = f_r;

endmodule

>>> src/rgblab_out.sv
// L*, a*, b* scaling, rounding to the output fraction and saturation.
// Depends on rgblab_pkg.
module rgblab_out #(
  parameter int OUT_FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               en,
  input  rgblab_pkg::f_vec_t f,
  output rgblab_pkg::lab_t   lab
);

  localparam int QB  = rgblab_pkg::QB;
  localparam int F_W = rgblab_pkg::F_W;
  localparam int VW  = F_W + 11;
  localparam int SH  = QB - OUT_FRAC_BITS;

  localparam logic signed [VW-1:0] K116   = VW'(116);
  localparam logic signed [VW-1:0] K500   = VW'(500);
  localparam logic signed [VW-1:0] K200   = VW'(200);
  localparam logic signed [VW-1:0] OFS16  = VW'(16) << QB;
  localparam logic signed [VW-1:0] LMAX_V = VW'(rgblab_pkg::lab_lmax(OUT_FRAC_BITS));
  localparam logic signed [VW-1:0] SMAX_V = VW'(32767);
  localparam logic signed [VW-1:0] SMIN_V = -VW'(32768);

  // round half away from zero
  function automatic logic signed [VW-1:0] rnd(input logic signed [VW-1:0] v);
    logic [VW-1:0] m;
    m = v[VW-1] ? VW'(~v + VW'(1)) : VW'(v);
    m = (m + (VW'(1) << (SH - 1))) >> SH;
    return v[VW-1] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [VW-1:0] v);
    if (v > SMAX_V) return 16'sh7fff;
    if (v < SMIN_V) return 16'sh8000;
    return v[15:0];
  endfunction

  logic signed [VW-1:0] f0s, f1s, f2s;
  logic signed [VW-1:0] lv_r, av_r, bv_r;
  logic signed [VW-1:0] lr, ar, br;
  rgblab_pkg::lab_t     lab_r;

  assign f0s = $signed(VW'(f[0]));
  assign f1s = $signed(VW'(f[1]));
  assign f2s = $signed(VW'(f[2]));

  always_ff @(posedge clk) begin
    if (en) begin
      lv_r <= f1s * K116 - OFS16;
      av_r <= (f0s - f1s) * K500;
      bv_r <= (f1s - f2s) * K200;
    end
  end

  assign lr = rnd(lv_r);
  assign ar = rnd(av_r);
  assign br = rnd(bv_r);

  always_ff @(posedge clk) begin
    if (en) begin
      if (lr[VW-1])        lab_r.lightness <= '0;
      else if (lr > LMAX_V) lab_r.lightness <= LMAX_V[14:0];
      else                 lab_r.lightness <= lr[14:0];
      lab_r.a_star <= sat16(ar);
      lab_r.b_star <= sat16(br);
    end
  end

  assign lab = lab_r;

endmodule

>>> src/rgb8_to_cielab_top.sv
// Top level of the sRGB (8-bit, D65) to CIELAB converter: valid pipeline
// and stage instances. Depends on rgblab_pkg, rgblab_* modules, assert_macros.svh.
//
//  Port group | Direction | Payload                 | Flow control
//  in_        | input     | rgblab_pkg::pix_t, 24 b | in_valid / in_stall
//  out_       | output    | rgblab_pkg::lab_t, 47 b | out_valid / out_stall
//
// One pixel per cycle unless a stall holds the pipeline; latency is set mostly by
// the 31-bit cube root, which resolves one bit every two stages.
// Reset clears only the valid bits; data registers are not reset.
// A stalled, valid output freezes every stage; in_stall follows at once, so
// no transaction is dropped or repeated. Bubbles move through like items.
`include "assert_macros.svh"
module rgb8_to_cielab_top #(
  parameter int OUT_FRAC_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rgblab_pkg::pix_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rgblab_pkg::lab_t out_data
);

  localparam int LAT = rgblab_pkg::LAT_TOTAL;
  localparam logic [14:0] LMAX15 = 15'(rgblab_pkg::lab_lmax(OUT_FRAC_BITS));

  logic                 adv;
  logic [LAT-1:0]       vld_r;
  logic [LAT-1:0]       vld_nxt;
  rgblab_pkg::lin_vec_t lin;
  rgblab_pkg::t_vec_t   t;
  rgblab_pkg::f_vec_t   f;

  assign adv      = !(vld_r[LAT-1] && out_stall);
  assign in_stall = !adv;
  assign vld_nxt  = {vld_r[LAT-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  rgblab_lin u_lin (
    .clk (clk),
    .en  (adv),
    .px  (in_data),
    .lin (lin)
  );

  rgblab_mat u_mat (
    .clk (clk),
    .en  (adv),
    .lin (lin),
    .t   (t)
  );

  for (genvar k = 0; k < 3; k++) begin : g_f
    rgblab_cbrt u_cbrt (
      .clk (clk),
      .en  (adv),
      .t   (t[k]),
      .f   (f[k])
    );
  end

  rgblab_out #(
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_out (
    .clk (clk),
    .en  (adv),
    .f   (f),
    .lab (out_data)
  );

  assign out_valid = vld_r[LAT-1];

  `ASSERT_NEXT(a_vld_hold, clk, rst_n, rst_n && !adv, $stable(vld_r), "valid pipeline moved while stalled")
  `ASSERT_NEXT(a_accept_enters, clk, rst_n, in_valid && !in_stall, vld_r[0], "accepted transaction not in pipeline")
  `ASSERT_IMPL(a_l_range, clk, rst_n, out_valid, out_data.lightness <= LMAX15, "lightness above full scale")

endmodule
